/* src/wsdf_pkg.sv */
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdf_pkg;

  // Width of the kept payload length; longer 64-bit lengths lose upper bits.
  localparam int unsigned LENGTH_BITS = 32;

  // Short length codes in the second header byte.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended length byte counts (EXT64 completes when the 3-bit count wraps).
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_DONE  = 3'd0;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       fin_flag;
    logic [2:0] reserved_bits;
    logic       last_of_frame;
    logic       empty_frame;
  } res_t;

endpackage

`default_nettype wire

/* src/websocket_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Byte-serial WebSocket frame deframer: parses headers, unmasks payload.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_       input      in_valid/in_stall  in_byte[7:0]
//  out_      output     out_valid/out_stall payload_byte, frame_opcode, fin_flag,
//                                           reserved_bits, last_of_frame, empty_frame
//
//  One byte is taken per cycle while in_stall is low; each byte gives zero or one result beat.
//  Each result is registered in the output stage (main or skid) before it appears.
//  A two-entry output stage (main + skid) lets input run while one result
//  waits; in_stall is registered and rises only when the skid entry is full.
//  Reset (rst_n low, synchronous) returns the parser to the first header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_byte,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] out_payload_byte,
  output      logic [3:0] out_frame_opcode,
  output      logic       out_fin_flag,
  output      logic [2:0] out_reserved_bits,
  output      logic       out_last_of_frame,
  output      logic       out_empty_frame
);

  localparam int unsigned LB = wsdf_pkg::LENGTH_BITS;

  wsdf_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]    hdr_cnt_r, hdr_cnt_nxt;
  logic [LB-1:0] rem_r, rem_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [1:0]    pos_r, pos_nxt;
  logic          mask_en_r, mask_en_nxt;
  logic [3:0]    opcode_r, opcode_nxt;
  logic          fin_r, fin_nxt;
  logic [2:0]    rsv_r, rsv_nxt;

  wsdf_pkg::res_t main_r, skid_r, res;
  logic           main_vld_r, skid_vld_r;
  logic           res_vld;

  logic          accept, out_take;
  logic [2:0]    cnt_inc;
  logic [LB-1:0] ext_rem, len_val, rem_dec, len7_ext;
  logic          len_known, mask_new, mask_done, hdr_end, empty_hit;
  logic [4:0]    key_shamt;
  logic [31:0]   key_shifted;

  assign accept   = in_valid && !in_stall;
  assign out_take = main_vld_r && !out_stall;
  assign in_stall = skid_vld_r;

  // ---------------- decode shared by state and result logic ----------------
  assign cnt_inc     = hdr_cnt_r + 3'd1;
  assign ext_rem     = {rem_r[LB-9:0], in_byte};
  assign rem_dec     = rem_r - {{(LB-1){1'b0}}, 1'b1};
  assign len7_ext    = {{(LB-7){1'b0}}, in_byte[6:0]};
  assign key_shamt   = {~pos_r, 3'b000};
  assign key_shifted = key_r >> key_shamt;

  always_comb begin
    len_known = 1'b0;
    len_val   = rem_r;
    mask_new  = mask_en_r;
    mask_done = 1'b0;
    unique case (phase_r)
      wsdf_pkg::PH_HDR1: begin
        len_known = (in_byte[6:0] != wsdf_pkg::LEN_EXT16) &&
                    (in_byte[6:0] != wsdf_pkg::LEN_EXT64);
        len_val   = len7_ext;
        mask_new  = in_byte[7];
      end
      wsdf_pkg::PH_EXT16: begin
        len_known = (cnt_inc == wsdf_pkg::EXT16_BYTES);
        len_val   = ext_rem;
      end
      wsdf_pkg::PH_EXT64: begin
        len_known = (cnt_inc == wsdf_pkg::EXT64_DONE);
        len_val   = ext_rem;
      end
      wsdf_pkg::PH_MASK: begin
        mask_done = cnt_inc[2];
      end
      default: begin
      end
    endcase
  end

  assign hdr_end   = (len_known && !mask_new) || mask_done;
  assign empty_hit = hdr_end && (len_val == '0);

  // ---------------- next state ----------------
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    mask_en_nxt = mask_en_r;
    opcode_nxt  = opcode_r;
    fin_nxt     = fin_r;
    rsv_nxt     = rsv_r;
    if (accept) begin
      unique case (phase_r)
        wsdf_pkg::PH_HDR1: begin
          mask_en_nxt = in_byte[7];
          hdr_cnt_nxt = '0;
          rem_nxt     = len_known ? len7_ext : '0;
          if (in_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
            phase_nxt = wsdf_pkg::PH_EXT16;
          end else if (in_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
            phase_nxt = wsdf_pkg::PH_EXT64;
          end else if (in_byte[7]) begin
            key_nxt   = '0;
            phase_nxt = wsdf_pkg::PH_MASK;
          end else begin
            pos_nxt   = '0;
            phase_nxt = empty_hit ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_DATA;
          end
        end
        wsdf_pkg::PH_EXT16, wsdf_pkg::PH_EXT64: begin
          rem_nxt     = ext_rem;
          hdr_cnt_nxt = cnt_inc;
          if (len_known) begin
            hdr_cnt_nxt = '0;
            if (mask_en_r) begin
              key_nxt   = '0;
              phase_nxt = wsdf_pkg::PH_MASK;
            end else begin
              pos_nxt   = '0;
              phase_nxt = empty_hit ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_DATA;
            end
          end
        end
        wsdf_pkg::PH_MASK: begin
          key_nxt     = {key_r[23:0], in_byte};
          hdr_cnt_nxt = cnt_inc;
          if (mask_done) begin
            hdr_cnt_nxt = '0;
            pos_nxt     = '0;
            phase_nxt   = empty_hit ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_DATA;
          end
        end
        wsdf_pkg::PH_DATA: begin
          pos_nxt = pos_r + 2'd1;
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = wsdf_pkg::PH_HDR0;
          end
        end
        default: begin
          fin_nxt     = in_byte[7];
          rsv_nxt     = in_byte[6:4];
          opcode_nxt  = in_byte[3:0];
          hdr_cnt_nxt = '0;
          phase_nxt   = wsdf_pkg::PH_HDR1;
        end
      endcase
    end
  end

  // ---------------- result beat ----------------
  always_comb begin
    res.frame_opcode  = opcode_r;
    res.fin_flag      = fin_r;
    res.reserved_bits = rsv_r;
    res.payload_byte  = '0;
    res.last_of_frame = 1'b0;
    res.empty_frame   = 1'b0;
    res_vld           = 1'b0;
    if (accept) begin
      if (phase_r == wsdf_pkg::PH_DATA) begin
        res_vld           = 1'b1;
        res.payload_byte  = in_byte ^ (mask_en_r ? key_shifted[7:0] : 8'h00);
        res.last_of_frame = (rem_dec == '0);
      end else if (empty_hit) begin
        res_vld           = 1'b1;
        res.last_of_frame = 1'b1;
        res.empty_frame   = 1'b1;
      end
    end
  end

  // ---------------- state registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wsdf_pkg::PH_HDR0;
      hdr_cnt_r <= '0;
      rem_r     <= '0;
      key_r     <= '0;
      pos_r     <= '0;
      mask_en_r <= 1'b0;
      opcode_r  <= '0;
      fin_r     <= 1'b0;
      rsv_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      rem_r     <= rem_nxt;
      key_r     <= key_nxt;
      pos_r     <= pos_nxt;
      mask_en_r <= mask_en_nxt;
      opcode_r  <= opcode_nxt;
      fin_r     <= fin_nxt;
      rsv_r     <= rsv_nxt;
    end
  end

  // ---------------- output stage: main register plus skid ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // input is stalled; drain skid into main once main is taken
      if (out_take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (res_vld) begin
      if (main_vld_r && !out_take) begin
        skid_vld_r <= 1'b1;
      end else begin
        main_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      main_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        main_r <= skid_r;
      end
    end else if (res_vld) begin
      if (main_vld_r && !out_take) begin
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end
  end

  assign out_valid         = main_vld_r;
  assign out_payload_byte  = main_r.payload_byte;
  assign out_frame_opcode  = main_r.frame_opcode;
  assign out_fin_flag      = main_r.fin_flag;
  assign out_reserved_bits = main_r.reserved_bits;
  assign out_last_of_frame = main_r.last_of_frame;
  assign out_empty_frame   = main_r.empty_frame;

  // ---------------- assertions ----------------
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid entry held while main register empty");

  a_data_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsdf_pkg::PH_DATA) |-> (rem_r != '0))
    else $error("payload phase with zero remaining length");

  a_mask_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsdf_pkg::PH_MASK) |-> !hdr_cnt_r[2])
    else $error("mask key byte count out of range");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.empty_frame) |-> (res.last_of_frame && phase_r != wsdf_pkg::PH_DATA))
    else $error("empty marker not marked last or raised in payload phase");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_vld_r && res_vld && main_vld_r && out_stall) |=> skid_vld_r)
    else $error("result lost while output stalled");

endmodule

`default_nettype wire
